>>> design/pgsp_pkg.sv
`timescale 1ns / 1ps

package pgsp_pkg;

    localparam int VALUE_BITS    = 32;
    localparam int COUNT_BITS    = 32;
    localparam int BIT_IDX_W     = $clog2(VALUE_BITS);
    // d*d stays below (2^(VALUE_BITS/2) + 2)^2, which fits in two extra bits
    localparam int SQ_BITS       = VALUE_BITS + 2;
    localparam int GAP           = 6;
    localparam int FIRST_DIVISOR = 2;

    typedef logic [VALUE_BITS-1:0] value_t;
    typedef logic [COUNT_BITS-1:0] count_t;
    typedef logic [SQ_BITS-1:0]    square_t;
    typedef logic [BIT_IDX_W-1:0]  bit_idx_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SQ_CHK,
        ST_DIV,
        ST_REM_CHK,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic load;
        logic div_start;
        logic div_step;
        logic next_div;
        logic commit;
        logic prime;
    } dp_cmd_t;

    typedef struct packed {
        logic lt_two;
        logic sq_gt;
        logic bit_last;
        logic rem_zero;
    } dp_status_t;

endpackage

>>> design/pgsp_in_if.sv
`timescale 1ns / 1ps

interface pgsp_in_if
    import pgsp_pkg::*;
;
    logic   valid;
    logic   ready;
    value_t candidate_value;
    logic   restart;

    modport source (output valid, output candidate_value, output restart, input ready);
    modport sink   (input valid, input candidate_value, input restart, output ready);
endinterface

>>> design/pgsp_out_if.sv
`timescale 1ns / 1ps

interface pgsp_out_if
    import pgsp_pkg::*;
;
    logic       valid;
    logic       ready;
    logic       prime_flag;
    logic [1:0] pairs_added;
    count_t     pair_count;
    value_t     latest_pair_top;

    modport source (output valid, output prime_flag, output pairs_added, output pair_count,
                    output latest_pair_top, input ready);
    modport sink   (input valid, input prime_flag, input pairs_added, input pair_count,
                    input latest_pair_top, output ready);
endinterface

>>> design/pgsp_datapath.sv
`timescale 1ns / 1ps

module pgsp_datapath
    import pgsp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  dp_cmd_t    cmd,
    output dp_status_t status,
    input  value_t     candidate_value,
    input  logic       restart,
    output logic       prime_flag,
    output logic [1:0] pairs_added,
    output count_t     pair_count,
    output value_t     latest_pair_top
);

    value_t   v_reg;
    value_t   d_reg;
    square_t  sq_reg;
    value_t   rem_reg;
    bit_idx_t cnt_reg;

    value_t   last_reg;
    value_t   before_reg;
    count_t   total_reg;
    value_t   top_reg;

    logic       prime_flag_reg;
    logic [1:0] added_reg;
    count_t     count_out_reg;
    value_t     top_out_reg;

    logic [VALUE_BITS:0]   rem_shift;
    logic [VALUE_BITS:0]   rem_sub;
    value_t                rem_next;
    square_t               sq_next;
    logic                  hit_last;
    logic                  hit_before;
    logic [1:0]            added;
    logic [COUNT_BITS+1:0] sum;
    count_t                total_next;

    // one restoring remainder step: bring in the next dividend bit
    always_comb
    begin
        rem_shift = {rem_reg, v_reg[cnt_reg]};
        rem_sub   = rem_shift - {1'b0, d_reg};
        if (rem_shift >= {1'b0, d_reg})
            rem_next = rem_sub[VALUE_BITS-1:0];
        else
            rem_next = rem_shift[VALUE_BITS-1:0];
    end

    // (d+1)^2 = d^2 + 2d + 1
    assign sq_next = sq_reg + {1'b0, d_reg, 1'b0} + SQ_BITS'(1);

    always_comb
    begin
        hit_last   = (last_reg != '0) &&
                     ({1'b0, v_reg} == {1'b0, last_reg} + (VALUE_BITS+1)'(GAP));
        hit_before = (before_reg != '0) &&
                     ({1'b0, v_reg} == {1'b0, before_reg} + (VALUE_BITS+1)'(GAP));
        added      = cmd.prime ? ({1'b0, hit_last} + {1'b0, hit_before}) : 2'd0;
        sum        = {2'b00, total_reg} + {{COUNT_BITS{1'b0}}, added};
        if (sum[COUNT_BITS+1:COUNT_BITS] != 2'b00)
            total_next = '1;
        else
            total_next = sum[COUNT_BITS-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            v_reg  <= candidate_value;
            d_reg  <= VALUE_BITS'(FIRST_DIVISOR);
            sq_reg <= SQ_BITS'(FIRST_DIVISOR * FIRST_DIVISOR);
        end
        else if (cmd.next_div)
        begin
            d_reg  <= d_reg + VALUE_BITS'(1);
            sq_reg <= sq_next;
        end

        if (cmd.div_start)
        begin
            rem_reg <= '0;
            cnt_reg <= BIT_IDX_W'(VALUE_BITS - 1);
        end
        else if (cmd.div_step)
        begin
            rem_reg <= rem_next;
            cnt_reg <= cnt_reg - BIT_IDX_W'(1);
        end

        if (cmd.commit)
        begin
            prime_flag_reg <= cmd.prime;
            added_reg      <= added;
            count_out_reg  <= total_next;
            top_out_reg    <= (added != 2'd0) ? v_reg : top_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_reg   <= '0;
            before_reg <= '0;
            total_reg  <= '0;
            top_reg    <= '0;
        end
        else if (cmd.load && restart)
        begin
            last_reg   <= '0;
            before_reg <= '0;
            total_reg  <= '0;
            top_reg    <= '0;
        end
        else if (cmd.commit && cmd.prime)
        begin
            before_reg <= last_reg;
            last_reg   <= v_reg;
            total_reg  <= total_next;
            if (added != 2'd0)
                top_reg <= v_reg;
        end
    end

    assign status.lt_two   = v_reg < VALUE_BITS'(FIRST_DIVISOR);
    assign status.sq_gt    = sq_reg > {2'b00, v_reg};
    assign status.bit_last = cnt_reg == '0;
    assign status.rem_zero = rem_reg == '0;

    assign prime_flag      = prime_flag_reg;
    assign pairs_added     = added_reg;
    assign pair_count      = count_out_reg;
    assign latest_pair_top = top_out_reg;

endmodule

>>> design/pgsp_ctrl.sv
`timescale 1ns / 1ps

module pgsp_ctrl
    import pgsp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    output logic       out_valid,
    input  logic       out_ready,
    input  dp_status_t status,
    output dp_cmd_t    cmd
);

    state_t state_reg;
    state_t state_next;
    logic   prime_reg;
    logic   prime_next;
    logic   out_valid_reg;
    logic   out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            prime_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            prime_reg     <= prime_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        prime_next     = prime_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd            = '0;
        cmd.prime      = prime_reg;
        in_ready       = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_SQ_CHK;
                end
            end
            ST_SQ_CHK:
            begin
                if (status.lt_two)
                begin
                    prime_next = 1'b0;
                    state_next = ST_FINISH;
                end
                else if (status.sq_gt)
                begin
                    prime_next = 1'b1;
                    state_next = ST_FINISH;
                end
                else
                begin
                    cmd.div_start = 1'b1;
                    state_next    = ST_DIV;
                end
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (status.bit_last)
                    state_next = ST_REM_CHK;
            end
            ST_REM_CHK:
            begin
                if (status.rem_zero)
                begin
                    prime_next = 1'b0;
                    state_next = ST_FINISH;
                end
                else
                begin
                    cmd.next_div = 1'b1;
                    state_next   = ST_SQ_CHK;
                end
            end
            ST_FINISH:
            begin
                // hold until the output register is free
                if (!out_valid_reg || out_ready)
                begin
                    cmd.commit     = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign out_valid = out_valid_reg;

endmodule

>>> design/prime_gap_six_pair_counter_core.sv
`timescale 1ns / 1ps

// Port     Dir   Payload
// cand     in    candidate_value[31:0], restart
// result   out   prime_flag, pairs_added[1:0], pair_count[31:0], latest_pair_top[31:0]
//
// One candidate at a time. Each divisor is tried by a square check, a bit-serial
// restoring remainder over all VALUE_BITS bits and a remainder check; a prime or a value
// below two ends at the square check, a value with a factor at the remainder check.
// Reset clears the remembered primes, pair count and latest top at once.
// A stalled result is held in the output register; the next candidate is taken meanwhile
// and its result waits until the held one is transferred.

module prime_gap_six_pair_counter_core
    import pgsp_pkg::*;
(
    input logic            clk,
    input logic            rst_n,
    pgsp_in_if.sink        cand,
    pgsp_out_if.source     result
);

    dp_cmd_t    cmd;
    dp_status_t status;

    pgsp_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (cand.valid),
        .in_ready  (cand.ready),
        .out_valid (result.valid),
        .out_ready (result.ready),
        .status    (status),
        .cmd       (cmd)
    );

    pgsp_datapath u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .status          (status),
        .candidate_value (cand.candidate_value),
        .restart         (cand.restart),
        .prime_flag      (result.prime_flag),
        .pairs_added     (result.pairs_added),
        .pair_count      (result.pair_count),
        .latest_pair_top (result.latest_pair_top)
    );

`ifndef SYNTH
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        cand.valid && cand.ready |=> !cand.ready)
        else $error("candidate taken while a test is still running");

    a_pairs_need_prime: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.pairs_added != 2'd0 |->
            result.prime_flag && result.latest_pair_top != '0 && result.pair_count != '0)
        else $error("pair reported without a prime top");

    a_pairs_range: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |-> result.pairs_added != 2'd3)
        else $error("pairs_added out of range");

    a_commit_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |-> !cand.ready && !cmd.load)
        else $error("result committed outside the finish step");
`endif

endmodule
